[rtl/core/running_lcm_of_resolutions_macros.svh]
// assertion helpers for the top-level rtl
`ifndef RUNNING_LCM_OF_RESOLUTIONS_MACROS_SVH
`define RUNNING_LCM_OF_RESOLUTIONS_MACROS_SVH

// same-cycle implication
`define RLCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlcm assertion failed");

// next-cycle implication
`define RLCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlcm assertion failed");

`endif

[rtl/core/rlcm_pkg.sv]
package rlcm_pkg;

    localparam int INPUT_BITS = 16;
    localparam int FIELD_BITS = 16;
    localparam int RUN_BITS   = 31;
    localparam int LANE_BITS  = (INPUT_BITS < FIELD_BITS) ? INPUT_BITS : FIELD_BITS;
    localparam int K_BITS     = $clog2(LANE_BITS);
    localparam int PROD_BITS  = RUN_BITS + LANE_BITS;

    localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

    typedef struct packed {
        logic [FIELD_BITS-1:0] width;
        logic [FIELD_BITS-1:0] height;
        logic                  skip;
        logic                  restart;
    } t_req;

    typedef struct packed {
        logic [RUN_BITS-1:0] lcm_width;
        logic [RUN_BITS-1:0] lcm_height;
        logic                any_seen;
        logic                overflow;
    } t_res;

    typedef struct packed {
        logic                 start;
        logic                 ack;
        logic [RUN_BITS-1:0]  m;
        logic [LANE_BITS-1:0] n;
    } t_lane_req;

    typedef struct packed {
        logic                done;
        logic                sat;
        logic [RUN_BITS-1:0] lcm;
    } t_lane_stat;

endpackage

[rtl/core/rlcm_lane.sv]
module rlcm_lane
    import rlcm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_lane_req  i_req,
    output t_lane_stat o_stat
);

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_GCD  = 3'd1;
    localparam logic [2:0] L_DIV  = 3'd2;
    localparam logic [2:0] L_MUL  = 3'd3;
    localparam logic [2:0] L_SAT  = 3'd4;
    localparam logic [2:0] L_DONE = 3'd5;

    logic [2:0]           r_st, n_st;
    logic [RUN_BITS-1:0]  r_m, n_m;
    logic [RUN_BITS-1:0]  r_a, n_a;
    logic [LANE_BITS-1:0] r_b, n_b;
    logic [LANE_BITS-1:0] r_n, n_n;
    logic [K_BITS-1:0]    r_k, n_k;
    logic [LANE_BITS-1:0] r_g, n_g;
    logic [LANE_BITS-1:0] r_rem, n_rem;
    logic [LANE_BITS-1:0] r_q, n_q;
    logic [K_BITS-1:0]    r_cnt, n_cnt;
    logic [PROD_BITS-1:0] r_prod, n_prod;
    logic [RUN_BITS-1:0]  r_lcm, n_lcm;
    logic                 r_sat, n_sat;
    logic [LANE_BITS:0]   trial;

    always_comb begin
        n_st   = r_st;
        n_m    = r_m;
        n_a    = r_a;
        n_b    = r_b;
        n_n    = r_n;
        n_k    = r_k;
        n_g    = r_g;
        n_rem  = r_rem;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_prod = r_prod;
        n_lcm  = r_lcm;
        n_sat  = r_sat;
        trial  = {r_rem, r_q[LANE_BITS-1]};
        unique case (r_st)
            L_IDLE: begin
                if (i_req.start) begin
                    n_m = i_req.m;
                    n_n = i_req.n;
                    n_a = i_req.m;
                    n_b = i_req.n;
                    n_k = '0;
                    if (i_req.n == '0) begin
                        n_lcm = '0;
                        n_sat = 1'b0;
                        n_st  = L_DONE;
                    end else begin
                        n_st = L_GCD;
                    end
                end
            end
            // binary gcd, one shift or subtract a cycle
            L_GCD: begin
                priority if (r_a == '0) begin
                    n_g   = LANE_BITS'(r_b << r_k);
                    n_rem = '0;
                    n_q   = r_n;
                    n_cnt = K_BITS'(LANE_BITS - 1);
                    n_st  = L_DIV;
                end else if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (r_a >= RUN_BITS'(r_b)) begin
                    n_a = (r_a - RUN_BITS'(r_b)) >> 1;
                end else begin
                    n_b = (r_b - LANE_BITS'(r_a)) >> 1;
                end
            end
            // restoring division n / g, one quotient bit a cycle
            L_DIV: begin
                if (trial >= {1'b0, r_g}) begin
                    n_rem = LANE_BITS'(trial - {1'b0, r_g});
                    n_q   = {r_q[LANE_BITS-2:0], 1'b1};
                end else begin
                    n_rem = LANE_BITS'(trial);
                    n_q   = {r_q[LANE_BITS-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_st = L_MUL;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            L_MUL: begin
                n_prod = PROD_BITS'(r_m) * PROD_BITS'(r_q);
                n_st   = L_SAT;
            end
            L_SAT: begin
                if (r_prod > PROD_BITS'(RUN_MAX)) begin
                    n_lcm = RUN_MAX;
                    n_sat = 1'b1;
                end else begin
                    n_lcm = r_prod[RUN_BITS-1:0];
                    n_sat = 1'b0;
                end
                n_st = L_DONE;
            end
            L_DONE: begin
                if (i_req.ack) begin
                    n_st = L_IDLE;
                end
            end
            default: begin
                n_st = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= L_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m    <= n_m;
        r_a    <= n_a;
        r_b    <= n_b;
        r_n    <= n_n;
        r_k    <= n_k;
        r_g    <= n_g;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
        r_prod <= n_prod;
        r_lcm  <= n_lcm;
        r_sat  <= n_sat;
    end

    assign o_stat.done = (r_st == L_DONE);
    assign o_stat.sat  = r_sat;
    assign o_stat.lcm  = r_lcm;

endmodule

[rtl/core/running_lcm_of_resolutions.sv]
// channel  direction  handshake                   payload
// in       input      i_in_valid / o_in_stall     i_in_req  (width, height, skip, restart)
// out      output     o_out_valid / i_out_stall   o_out_res (lcm_width, lcm_height, any_seen,
//                                                            overflow)
//
// a skipped or seeding request waits in the pending state for the output register
// a combining request runs both lanes side by side: binary gcd at one step a cycle
// of the 31-bit running value and the 16-bit input, a restoring divide, multiply,
// saturate and merge; a lane whose new dimension is zero goes straight to done with a
// zero result
// one request is in flight at a time; the output register holds a result under stall
// reset is synchronous, active low, and clears the running values and flags
module running_lcm_of_resolutions
    import rlcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_res o_out_res
);

`include "running_lcm_of_resolutions_macros.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_PEND = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [RUN_BITS-1:0] r_run_w, n_run_w;
    logic [RUN_BITS-1:0] r_run_h, n_run_h;
    logic                r_seen, n_seen;
    logic                r_ovf, n_ovf;
    logic                r_out_valid, n_out_valid;
    t_res                r_out, n_out;

    t_lane_req  req_w, req_h;
    t_lane_stat stat_w, stat_h;

    logic                 in_acc;
    logic                 merge;
    logic [LANE_BITS-1:0] w_n, h_n;

    assign in_acc = i_in_valid && !o_in_stall;
    assign merge  = (r_state == ST_BUSY) && stat_w.done && stat_h.done;
    assign w_n    = i_in_req.width[LANE_BITS-1:0];
    assign h_n    = i_in_req.height[LANE_BITS-1:0];

    always_comb begin
        req_w.start = 1'b0;
        req_w.ack   = merge;
        req_w.m     = r_run_w;
        req_w.n     = w_n;
        req_h.start = 1'b0;
        req_h.ack   = merge;
        req_h.m     = r_run_h;
        req_h.n     = h_n;

        n_state     = r_state;
        n_run_w     = r_run_w;
        n_run_h     = r_run_h;
        n_seen      = r_seen;
        n_ovf       = r_ovf;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    // restart never reaches the lanes: with skip it leaves nothing seen
                    priority if (i_in_req.skip) begin
                        if (i_in_req.restart) begin
                            n_run_w = '0;
                            n_run_h = '0;
                            n_seen  = 1'b0;
                            n_ovf   = 1'b0;
                        end
                        n_state = ST_PEND;
                    end else if (i_in_req.restart || !r_seen) begin
                        n_run_w = RUN_BITS'(w_n);
                        n_run_h = RUN_BITS'(h_n);
                        n_seen  = 1'b1;
                        if (i_in_req.restart) begin
                            n_ovf = 1'b0;
                        end
                        n_state = ST_PEND;
                    end else begin
                        req_w.start = 1'b1;
                        req_h.start = 1'b1;
                        n_state     = ST_BUSY;
                    end
                end
            end
            ST_BUSY: begin
                if (merge) begin
                    n_run_w = stat_w.lcm;
                    n_run_h = stat_h.lcm;
                    n_ovf   = r_ovf | stat_w.sat | stat_h.sat;
                    n_state = ST_PEND;
                end
            end
            ST_PEND: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.lcm_width  = r_run_w;
                    n_out.lcm_height = r_run_h;
                    n_out.any_seen   = r_seen;
                    n_out.overflow   = r_ovf;
                    n_out_valid      = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_run_w     <= '0;
            r_run_h     <= '0;
            r_seen      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run_w     <= n_run_w;
            r_run_h     <= n_run_h;
            r_seen      <= n_seen;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    rlcm_lane u_lane_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_w),
        .o_stat  (stat_w)
    );

    rlcm_lane u_lane_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_h),
        .o_stat  (stat_h)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    `RLCM_ASSERT_IMP(a_lane_done_busy, i_clk, i_rst_n, stat_w.done || stat_h.done, r_state == ST_BUSY)
    `RLCM_ASSERT_NXT(a_accept_blocks, i_clk, i_rst_n, in_acc, o_in_stall)
    `RLCM_ASSERT_IMP(a_empty_pass, i_clk, i_rst_n, !r_seen, r_run_w == '0 && r_run_h == '0 && !r_ovf)
    `RLCM_ASSERT_IMP(a_ovf_from_merge, i_clk, i_rst_n, $rose(r_ovf), $past(r_state) == ST_BUSY)

endmodule

[verif/tb_top.sv]
module tb_top
    import rlcm_pkg::*;
;

    typedef enum int {
        PH_CALM,
        PH_SENDER_GAPS,
        PH_RECEIVER_STALLS,
        PH_BOTH,
        PH_BACKPRESSURE
    } t_phase;

    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 100;

    localparam logic [9:0][FIELD_BITS-1:0] COMMON_W = {
        16'd640, 16'd800, 16'd1024, 16'd1280, 16'd1366,
        16'd1440, 16'd1600, 16'd1920, 16'd2560, 16'd3840
    };
    localparam logic [9:0][FIELD_BITS-1:0] COMMON_H = {
        16'd480, 16'd600, 16'd720, 16'd768, 16'd900,
        16'd1050, 16'd1080, 16'd1200, 16'd1440, 16'd2160
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_req i_in_req = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_res o_out_res;

    running_lcm_of_resolutions dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_req display_q[$];
    t_res lcm_due_q[$];
    int unsigned bad_cnt = 0;
    logic req_taken = 1'b0;
    logic hold_off = 1'b0;
    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;
    t_phase cur_phase = PH_CALM;

    // running state of the predictor
    logic [RUN_BITS-1:0] acc_width = '0;
    logic [RUN_BITS-1:0] acc_height = '0;
    logic pass_open = 1'b0;
    logic sat_sticky = 1'b0;

    function automatic logic [RUN_BITS-1:0] lcm_clamped(input logic [63:0] m,
                                                        input logic [63:0] n,
                                                        output logic clipped);
        logic [63:0] a, b, r, prod;
        clipped = 1'b0;
        a = m;
        b = n;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        if (a == 0) return '0;
        prod = (m / a) * n;
        if (prod > RUN_MAX) begin
            clipped = 1'b1;
            return RUN_MAX;
        end
        return prod[RUN_BITS-1:0];
    endfunction

    function automatic t_res resolution_step(input t_req rq);
        logic [RUN_BITS-1:0] w, h;
        logic clip_w, clip_h;
        t_res res;
        w = RUN_BITS'(rq.width[LANE_BITS-1:0]);
        h = RUN_BITS'(rq.height[LANE_BITS-1:0]);
        if (rq.restart) begin
            acc_width = '0;
            acc_height = '0;
            pass_open = 1'b0;
            sat_sticky = 1'b0;
        end
        if (!rq.skip) begin
            if (!pass_open) begin
                acc_width = w;
                acc_height = h;
                pass_open = 1'b1;
            end else begin
                acc_width = lcm_clamped(64'(acc_width), 64'(w), clip_w);
                acc_height = lcm_clamped(64'(acc_height), 64'(h), clip_h);
                if (clip_w || clip_h) sat_sticky = 1'b1;
            end
        end
        res.lcm_width = acc_width;
        res.lcm_height = acc_height;
        res.any_seen = pass_open;
        res.overflow = sat_sticky;
        return res;
    endfunction

    function automatic t_req mk_req(input int unsigned w, input int unsigned h,
                                    input logic skip, input logic restart);
        t_req rq;
        rq.width = FIELD_BITS'(w);
        rq.height = FIELD_BITS'(h);
        rq.skip = skip;
        rq.restart = restart;
        return rq;
    endfunction

    function automatic logic [FIELD_BITS-1:0] pick_dim(input logic horiz);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 60) return horiz ? COMMON_W[$urandom_range(9)] : COMMON_H[$urandom_range(9)];
        else if (sel < 85) return FIELD_BITS'($urandom_range(64, 1));
        else if (sel < 95) return FIELD_BITS'($urandom);
        return '0;
    endfunction

    // passes open with a restart unless they are noise; a tenth of them are pure noise
    task automatic add_random_passes(input int unsigned n_taken);
        int unsigned taken, pass_len, k;
        logic noise;
        t_req rq;
        taken = 0;
        while (taken < n_taken) begin
            noise = ($urandom_range(99) < 10);
            pass_len = $urandom_range(8, 1);
            for (k = 0; k < pass_len; k++) begin
                if (noise) begin
                    rq.width = FIELD_BITS'($urandom);
                    rq.height = FIELD_BITS'($urandom);
                    rq.skip = 1'($urandom_range(1));
                    rq.restart = 1'($urandom_range(1));
                end else begin
                    rq.width = pick_dim(1'b1);
                    rq.height = pick_dim(1'b0);
                    rq.skip = ($urandom_range(99) < 8);
                    rq.restart = (k == 0) || ($urandom_range(99) < 3);
                end
                display_q.push_back(rq);
                if (!rq.skip) taken++;
            end
        end
    endtask

    task automatic flag_bad(input string what, input t_res want, input t_res got);
        bad_cnt++;
        if (bad_cnt <= 10) begin
            $display("%s: expected w=%0d h=%0d seen=%0b ovf=%0b, got w=%0d h=%0d seen=%0b ovf=%0b",
                     what, want.lcm_width, want.lcm_height, want.any_seen, want.overflow,
                     got.lcm_width, got.lcm_height, got.any_seen, got.overflow);
        end
    endtask

    task automatic run_phase(input t_phase ph, input int unsigned n_taken);
        @(posedge i_clk);
        cur_phase <= ph;
        case (ph)
            PH_SENDER_GAPS: begin
                send_gap_pct <= 82;
                recv_stall_pct <= 0;
            end
            PH_RECEIVER_STALLS: begin
                send_gap_pct <= 0;
                recv_stall_pct <= 82;
            end
            PH_BOTH: begin
                send_gap_pct <= 28;
                recv_stall_pct <= 28;
            end
            default: begin
                send_gap_pct <= 0;
                recv_stall_pct <= 0;
            end
        endcase
        add_random_passes(n_taken);
        @(posedge i_clk);
        while (display_q.size() != 0 || i_in_valid || lcm_due_q.size() != 0) @(posedge i_clk);
    endtask

    // long receiver hold while the sender keeps offering requests
    initial begin
        wait (cur_phase == PH_BACKPRESSURE);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // request driver
    always @(negedge i_clk) begin
        logic nxt_valid;
        t_req nxt_req;
        nxt_valid = i_in_valid;
        nxt_req = i_in_req;
        if (i_rst_n && (!i_in_valid || req_taken)) begin
            nxt_valid = 1'b0;
            if (display_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                nxt_req = display_q.pop_front();
                nxt_valid = 1'b1;
            end
        end
        i_in_valid <= nxt_valid;
        i_in_req <= nxt_req;
    end

    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && (hold_off || ($urandom_range(99) < recv_stall_pct));
    end

    always @(posedge i_clk) begin
        t_res want;
        req_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) lcm_due_q.push_back(resolution_step(i_in_req));
            if (o_out_valid && !i_out_stall) begin
                if (lcm_due_q.size() == 0) begin
                    flag_bad("unexpected result", '0, o_out_res);
                end else begin
                    want = lcm_due_q.pop_front();
                    if (o_out_res.lcm_width !== want.lcm_width
                        || o_out_res.lcm_height !== want.lcm_height
                        || o_out_res.any_seen !== want.any_seen
                        || o_out_res.overflow !== want.overflow) begin
                        flag_bad("wrong result", want, o_out_res);
                    end
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // seeding, combining, skips and zero dimensions
        display_q.push_back(mk_req(1920, 1080, 1'b0, 1'b1));
        display_q.push_back(mk_req(1280, 1024, 1'b0, 1'b0));
        display_q.push_back(mk_req(65535, 65535, 1'b0, 1'b0));
        display_q.push_back(mk_req(7, 7, 1'b1, 1'b0));
        display_q.push_back(mk_req(0, 1080, 1'b0, 1'b0));
        display_q.push_back(mk_req(5, 0, 1'b0, 1'b0));
        display_q.push_back(mk_req(0, 0, 1'b0, 1'b0));
        display_q.push_back(mk_req(0, 0, 1'b0, 1'b1));
        display_q.push_back(mk_req(3, 3, 1'b0, 1'b0));
        display_q.push_back(mk_req(65535, 65535, 1'b1, 1'b1));
        display_q.push_back(mk_req(1, 1, 1'b1, 1'b0));
        // saturation on both sides, then carried forward
        display_q.push_back(mk_req(65521, 65519, 1'b0, 1'b1));
        display_q.push_back(mk_req(65519, 65497, 1'b0, 1'b0));
        display_q.push_back(mk_req(2, 3, 1'b0, 1'b0));
        display_q.push_back(mk_req(1, 1, 1'b0, 1'b0));
        // restart clears the overflow; one side saturates alone
        display_q.push_back(mk_req(65535, 1, 1'b0, 1'b1));
        display_q.push_back(mk_req(32768, 2, 1'b0, 1'b0));
        display_q.push_back(mk_req(65534, 65535, 1'b0, 1'b0));
        // largest value just below the ceiling
        display_q.push_back(mk_req(1, 65535, 1'b0, 1'b1));
        display_q.push_back(mk_req(1, 32768, 1'b0, 1'b0));
        display_q.push_back(mk_req(1, 2, 1'b0, 1'b0));
        display_q.push_back(mk_req(65535, 65535, 1'b0, 1'b0));
        display_q.push_back(mk_req(1, 1, 1'b0, 1'b1));
        run_phase(PH_CALM, 250);
        run_phase(PH_SENDER_GAPS, 200);
        run_phase(PH_RECEIVER_STALLS, 200);
        run_phase(PH_BOTH, 250);
        run_phase(PH_BACKPRESSURE, 100);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_cnt == 0 && lcm_due_q.size() == 0) begin
            $display("running_lcm_of_resolutions: match");
        end else begin
            $display("running_lcm_of_resolutions: mismatch");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("running_lcm_of_resolutions: mismatch");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/rlcm_pkg.sv
rtl/core/rlcm_lane.sv
rtl/core/running_lcm_of_resolutions.sv
verif/tb_top.sv
